/* hw/rtl/shf_pkg.sv */
// Shared types and constants for the sync-header frame parser.
package shf_pkg;

   localparam int DEFAULT_MAX_PAYLOAD = 512;

   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int POS_W  = 9;
   localparam int FLEN_W = 10;
   localparam int CFG_W  = 10;

   localparam logic [CFG_W-1:0]  CFG_RESET = 10'd512;

   localparam logic [BYTE_W-1:0] HDR1_BYTE = 8'hAA;
   localparam logic [BYTE_W-1:0] HDR2_BYTE = 8'h55;

   localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUM_GOOD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM_BAD  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] byte_value;
      logic [POS_W-1:0]  position;
      logic [FLEN_W-1:0] frame_length;
      logic [BYTE_W-1:0] computed_sum;
   } res_type;

endpackage

/* hw/rtl/sync_header_frame_parser.sv */
// Top level of the sync-header frame parser.
// Takes one received byte per transfer and hunts for the header 0xAA 0x55, then reads a
// command byte, a big-endian 16-bit length, the payload and an 8-bit sum checksum over
// command, length and payload. Every payload byte gives one result; the checksum byte
// gives a good or bad verdict. Header, command and length bytes give none, and a frame
// whose length is zero or above min(max_payload_len, MAX_PAYLOAD) is dropped silently.
// Throughput is one byte per clock while no result is held back: a byte waits in the
// input register, the parser handles it in a single pass and its result lands in the
// output register, which drives rsp_valid. A result held back by rsp_ready
// stalls the next result-producing byte in the input register. The csr port is always
// ready and should only be written while no frame is in flight.
module sync_header_frame_parser
   import shf_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [BYTE_W-1:0] rsp_command,
   output logic [BYTE_W-1:0] rsp_byte_value,
   output logic [POS_W-1:0]  rsp_position,
   output logic [FLEN_W-1:0] rsp_frame_length,
   output logic [BYTE_W-1:0] rsp_computed_sum,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_max_payload_len
);

   logic [CFG_W-1:0]  max_len_ff;
   logic              item_valid;
   logic [BYTE_W-1:0] item_byte;
   logic              advance;
   logic              emit;
   logic              slot_free;
   res_type           result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_payload_len;
      end
   end

   // Advance a byte unless its result has nowhere to go.
   assign advance = item_valid && (!emit || slot_free);

   shf_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   shf_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (item_byte),
      .max_len (max_len_ff),
      .emit    (emit),
      .result  (result)
   );

   shf_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (advance && emit),
      .result           (result),
      .slot_free        (slot_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_command      (rsp_command),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_position     (rsp_position),
      .rsp_frame_length (rsp_frame_length),
      .rsp_computed_sum (rsp_computed_sum)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over one not yet taken");

   a_item_waits: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !advance) |-> (emit && rsp_valid && !rsp_ready))
      else $error("input byte held without a stalled result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_ready)
      else $error("input side not ready with an empty input register");

endmodule

/* hw/rtl/shf_in_stage.sv */
// Input register: holds one received byte until the parser takes it.
module shf_in_stage
   import shf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              advance,
   output logic              item_valid,
   output logic [BYTE_W-1:0] item_byte
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

/* hw/rtl/shf_parser.sv */
// Frame parser state machine: header hunt, command, length, payload, checksum.
module shf_parser
   import shf_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [CFG_W-1:0]  max_len,
   output logic              emit,
   output res_type           result
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_CMD  = 3'd2,
      PH_LENH = 3'd3,
      PH_LENL = 3'd4,
      PH_DATA = 3'd5,
      PH_SUM  = 3'd6
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] lenh_ff, lenh_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;

   logic [15:0]       len_full;
   logic              len_ok;
   logic [BYTE_W-1:0] sum_next;
   logic [LEN_W-1:0]  cnt_next;

   assign len_full = {lenh_ff, rx_byte};
   assign len_ok   = (len_full != 16'd0) && (len_full <= 16'(max_len))
                     && (len_full <= 16'(MAX_PAYLOAD));
   assign sum_next = sum_ff + rx_byte;
   assign cnt_next = cnt_ff + LEN_W'(1);

   assign emit = (phase_ff == PH_DATA) || (phase_ff == PH_SUM);

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      lenh_in  = lenh_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;

      result.kind         = KIND_DATA;
      result.command      = cmd_ff;
      result.byte_value   = rx_byte;
      result.position     = POS_W'(cnt_ff);
      result.frame_length = FLEN_W'(len_ff);
      result.computed_sum = sum_next;

      unique case (phase_ff)
         PH_HDR1: begin
            phase_in = (rx_byte == HDR1_BYTE) ? PH_HDR2 : PH_HDR1;
         end
         PH_HDR2: begin
            phase_in = (rx_byte == HDR2_BYTE) ? PH_CMD : PH_HDR1;
         end
         PH_CMD: begin
            cmd_in   = rx_byte;
            sum_in   = rx_byte;
            phase_in = PH_LENH;
         end
         PH_LENH: begin
            lenh_in  = rx_byte;
            sum_in   = sum_next;
            phase_in = PH_LENL;
         end
         PH_LENL: begin
            // Only a length that passes the limit check reaches the payload phase.
            len_in   = LEN_W'(len_full);
            sum_in   = sum_next;
            cnt_in   = '0;
            phase_in = len_ok ? PH_DATA : PH_HDR1;
         end
         PH_DATA: begin
            sum_in = sum_next;
            cnt_in = cnt_next;
            if (cnt_next == len_ff) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            result.kind         = (rx_byte == sum_ff) ? KIND_SUM_GOOD : KIND_SUM_BAD;
            result.position     = '0;
            result.computed_sum = sum_ff;
            phase_in            = PH_HDR1;
         end
         default: begin
            phase_in = (rx_byte == HDR1_BYTE) ? PH_HDR2 : PH_HDR1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR1;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
      if (advance) begin
         cmd_ff  <= cmd_in;
         lenh_ff <= lenh_in;
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
      end
   end

   a_cnt_below_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (cnt_ff < len_ff))
      else $error("payload count reached declared length inside payload phase");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (len_ff != '0 && 32'(len_ff) <= 32'(MAX_PAYLOAD)))
      else $error("payload phase entered with an out-of-range length");

   a_sum_returns: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_SUM) |=> (phase_ff == PH_HDR1))
      else $error("checksum byte did not restart the header hunt");

endmodule

/* hw/rtl/shf_out_stage.sv */
// Result register: holds one result until the consumer takes it.
module shf_out_stage
   import shf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  res_type           result,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [BYTE_W-1:0] rsp_command,
   output logic [BYTE_W-1:0] rsp_byte_value,
   output logic [POS_W-1:0]  rsp_position,
   output logic [FLEN_W-1:0] rsp_frame_length,
   output logic [BYTE_W-1:0] rsp_computed_sum
);

   logic    valid_ff;
   logic    valid_in;
   res_type res_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = res_ff.kind;
   assign rsp_command      = res_ff.command;
   assign rsp_byte_value   = res_ff.byte_value;
   assign rsp_position     = res_ff.position;
   assign rsp_frame_length = res_ff.frame_length;
   assign rsp_computed_sum = res_ff.computed_sum;

endmodule
